FILE: src/itf_pkg.sv
// Shared types, constants and helpers for the integer-to-text formatter.
`timescale 1ns / 1ps

package itf_pkg;

    localparam int WIDTH_LIMIT_DEF = 64;
    localparam int VALUE_BITS_DEF  = 32;

    // quotient bits resolved per divider cycle
    localparam int DIGIT_STEP = 4;

    localparam logic [4:0] BASE_MIN = 5'd2;
    localparam logic [4:0] BASE_DEC = 5'd10;
    localparam logic [4:0] BASE_HEX = 5'd16;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_ALPHA = 8'h37;  // 'A' - 10
    localparam logic [7:0] CHAR_COMMA = 8'h2C;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;

    typedef struct packed {
        logic signed [31:0] value;
        logic [4:0]         base;
        logic               signed_mode;
        logic [6:0]         width;
        logic               left_justify;
        logic [7:0]         fill_char;
    } itf_in_t;

    typedef struct packed {
        logic [7:0] char_code;
        logic       last;
    } itf_out_t;

    function automatic logic [7:0] digit_char(input logic [3:0] d);
        logic [7:0] ext;
        ext = {4'b0000, d};
        return (d <= 4'd9) ? (CHAR_ZERO + ext) : (CHAR_ALPHA + ext);
    endfunction

endpackage

FILE: src/itf_div.sv
// Iterative restoring divider: unsigned value by a small base, four quotient bits per cycle.
`timescale 1ns / 1ps

module itf_div #(
    parameter int VALUE_BITS = itf_pkg::VALUE_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [VALUE_BITS-1:0] dividend,
    input  logic [4:0]            divisor,
    output logic                  done,
    output logic [VALUE_BITS-1:0] quotient,
    output logic [3:0]            remainder
);
    import itf_pkg::*;

    localparam int DIV_BITS = ((VALUE_BITS + DIGIT_STEP - 1) / DIGIT_STEP) * DIGIT_STEP;
    localparam int STEPS    = DIV_BITS / DIGIT_STEP;
    localparam int CNT_W    = $clog2(STEPS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(STEPS - 1);

    logic                run_reg;
    logic                done_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [DIV_BITS-1:0] work_reg;
    logic [DIV_BITS-1:0] work_next;
    logic [3:0]          rem_reg;
    logic [3:0]          rem_next;
    logic [4:0]          part;

    // dividend shifts out at the top, quotient bits shift in at the bottom
    always_comb
    begin
        work_next = work_reg;
        rem_next  = rem_reg;
        part      = '0;
        for (int i = 0; i < DIGIT_STEP; i++)
        begin
            part      = {rem_next, work_next[DIV_BITS-1]};
            work_next = {work_next[DIV_BITS-2:0], 1'b0};
            if (part >= divisor)
            begin
                rem_next     = 4'(part - divisor);
                work_next[0] = 1'b1;
            end
            else
            begin
                rem_next = part[3:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= run_reg && (cnt_reg == CNT_LAST);
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                    run_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            work_reg <= DIV_BITS'(dividend);
            rem_reg  <= '0;
        end
        else if (run_reg)
        begin
            work_reg <= work_next;
            rem_reg  <= rem_next;
        end
    end

    assign done      = done_reg;
    assign quotient  = work_reg[VALUE_BITS-1:0];
    assign remainder = rem_reg;

endmodule

FILE: src/integer_to_text_formatter.sv
// Top level: formats one integer as ASCII text, one character per strobe.
// Sequence: each digit comes straight from the value in base 16 and from the shared divider in
//   other bases, then any comma and minus sign, then a read setup, then max(width, length)
//   characters at one character per cycle; busy falls as the last character is shown.
// Throughput: one item at a time; a new start is taken once busy is low.
// Reset (rst_n, async, active low) returns the sequencer to idle with no strobe pending.
`timescale 1ns / 1ps

module integer_to_text_formatter #(
    parameter int WIDTH_LIMIT = itf_pkg::WIDTH_LIMIT_DEF,
    parameter int VALUE_BITS  = itf_pkg::VALUE_BITS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  itf_pkg::itf_in_t item,
    output logic             strobe,
    output itf_pkg::itf_out_t result
);
    import itf_pkg::*;

    localparam int TXT_DEPTH = VALUE_BITS + 1;
    localparam int TXT_AW    = $clog2(TXT_DEPTH);
    localparam int LEN_W     = $clog2(TXT_DEPTH + 1);
    localparam int PAD_W     = $clog2(WIDTH_LIMIT + 1);
    localparam int CMP_W     = (PAD_W > LEN_W) ? PAD_W : LEN_W;

    typedef enum logic [3:0] {
        S_IDLE, S_DIGIT, S_WAIT, S_COMMA, S_SIGN, S_PREP, S_LPAD, S_TEXT, S_RPAD
    } state_t;

    state_t              state_reg, state_next;
    logic                strobe_reg, strobe_next;
    itf_out_t            result_reg, result_next;
    logic [LEN_W-1:0]    len_reg, len_next;
    logic [1:0]          grp_reg, grp_next;
    logic [PAD_W-1:0]    pad_reg, pad_next;
    logic [TXT_AW-1:0]   rptr_reg, rptr_next;

    logic [VALUE_BITS-1:0] mag_reg, mag_next;
    logic [4:0]            base_reg, base_next;
    logic [PAD_W-1:0]      width_reg, width_next;
    logic [7:0]            fill_reg, fill_next;
    logic                  left_reg, left_next;
    logic                  neg_reg, neg_next;

    logic [7:0]            txt_mem [TXT_DEPTH];
    logic [7:0]            rd_data_reg;
    logic                  wr_en, rd_en;
    logic [TXT_AW-1:0]     rd_addr;
    logic [7:0]            wr_data;

    logic                  div_start, div_done;
    logic [VALUE_BITS-1:0] div_quo;
    logic [3:0]            div_rem;

    logic                  base16, digit_valid;
    logic [3:0]            dig_val;
    logic [VALUE_BITS-1:0] dig_quo;
    logic [VALUE_BITS-1:0] v_in;
    logic                  neg_in;
    logic [PAD_W-1:0]      pad_calc;
    logic [LEN_W-1:0]      len_m1;

    itf_div #(.VALUE_BITS(VALUE_BITS)) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (mag_reg),
        .divisor   (base_reg),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    assign base16      = (base_reg == BASE_HEX);
    assign dig_val     = base16 ? mag_reg[3:0] : div_rem;
    assign dig_quo     = base16 ? (mag_reg >> 4) : div_quo;
    assign digit_valid = ((state_reg == S_DIGIT) && base16) || ((state_reg == S_WAIT) && div_done);
    assign v_in        = item.value[VALUE_BITS-1:0];
    assign neg_in      = item.signed_mode && v_in[VALUE_BITS-1];
    assign len_m1      = len_reg - 1'b1;
    assign pad_calc    = (CMP_W'(width_reg) > CMP_W'(len_reg))
                         ? PAD_W'(CMP_W'(width_reg) - CMP_W'(len_reg)) : '0;

    always_comb
    begin
        state_next  = state_reg;
        strobe_next = 1'b0;
        result_next = result_reg;
        len_next    = len_reg;
        grp_next    = grp_reg;
        pad_next    = pad_reg;
        rptr_next   = rptr_reg;
        mag_next    = mag_reg;
        base_next   = base_reg;
        width_next  = width_reg;
        fill_next   = fill_reg;
        left_next   = left_reg;
        neg_next    = neg_reg;
        wr_en       = 1'b0;
        wr_data     = CHAR_ZERO;
        rd_en       = 1'b0;
        rd_addr     = rptr_reg;
        div_start   = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    mag_next = neg_in ? ((~v_in) + VALUE_BITS'(1)) : v_in;
                    neg_next = neg_in;
                    if (item.base < BASE_MIN)
                        base_next = BASE_MIN;
                    else if (item.base > BASE_HEX)
                        base_next = BASE_HEX;
                    else
                        base_next = item.base;
                    width_next = (item.width > 7'(WIDTH_LIMIT)) ? '0 : PAD_W'(item.width);
                    fill_next  = (item.fill_char == 8'h00) ? CHAR_SPACE : item.fill_char;
                    left_next  = item.left_justify;
                    len_next   = '0;
                    grp_next   = '0;
                    state_next = S_DIGIT;
                end
            end
            S_DIGIT:
            begin
                if (!base16)
                begin
                    div_start  = 1'b1;
                    state_next = S_WAIT;
                end
            end
            S_WAIT:
            begin
                // digit handled below once the divider finishes
            end
            S_COMMA:
            begin
                wr_en      = 1'b1;
                wr_data    = CHAR_COMMA;
                len_next   = len_reg + 1'b1;
                state_next = S_DIGIT;
            end
            S_SIGN:
            begin
                wr_en      = 1'b1;
                wr_data    = CHAR_MINUS;
                len_next   = len_reg + 1'b1;
                state_next = S_PREP;
            end
            S_PREP:
            begin
                // text is stored low digit first; fetch the top character
                rd_en      = 1'b1;
                rd_addr    = len_m1[TXT_AW-1:0];
                rptr_next  = len_m1[TXT_AW-1:0];
                pad_next   = pad_calc;
                state_next = (!left_reg && (pad_calc != '0)) ? S_LPAD : S_TEXT;
            end
            S_LPAD:
            begin
                strobe_next           = 1'b1;
                result_next.char_code = fill_reg;
                result_next.last      = 1'b0;
                pad_next              = pad_reg - 1'b1;
                if (pad_reg == PAD_W'(1))
                    state_next = S_TEXT;
            end
            S_TEXT:
            begin
                strobe_next           = 1'b1;
                result_next.char_code = rd_data_reg;
                result_next.last      = (rptr_reg == '0) && (pad_reg == '0);
                if (rptr_reg == '0)
                begin
                    state_next = (pad_reg != '0) ? S_RPAD : S_IDLE;
                end
                else
                begin
                    rd_en     = 1'b1;
                    rd_addr   = rptr_reg - 1'b1;
                    rptr_next = rptr_reg - 1'b1;
                end
            end
            S_RPAD:
            begin
                strobe_next           = 1'b1;
                result_next.char_code = fill_reg;
                result_next.last      = (pad_reg == PAD_W'(1));
                pad_next              = pad_reg - 1'b1;
                if (pad_reg == PAD_W'(1))
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (digit_valid)
        begin
            wr_en    = 1'b1;
            wr_data  = digit_char(dig_val);
            len_next = len_reg + 1'b1;
            mag_next = dig_quo;
            if (dig_quo != '0)
            begin
                if ((base_reg == BASE_DEC) && (grp_reg == 2'd2))
                begin
                    grp_next   = '0;
                    state_next = S_COMMA;
                end
                else
                begin
                    grp_next   = (grp_reg == 2'd2) ? 2'd0 : grp_reg + 1'b1;
                    state_next = S_DIGIT;
                end
            end
            else
            begin
                state_next = neg_reg ? S_SIGN : S_PREP;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            strobe_reg <= 1'b0;
            result_reg <= '0;
            len_reg    <= '0;
            grp_reg    <= '0;
            pad_reg    <= '0;
            rptr_reg   <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            strobe_reg <= strobe_next;
            result_reg <= result_next;
            len_reg    <= len_next;
            grp_reg    <= grp_next;
            pad_reg    <= pad_next;
            rptr_reg   <= rptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg   <= mag_next;
        base_reg  <= base_next;
        width_reg <= width_next;
        fill_reg  <= fill_next;
        left_reg  <= left_next;
        neg_reg   <= neg_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            txt_mem[len_reg[TXT_AW-1:0]] <= wr_data;
        if (rd_en)
            rd_data_reg <= txt_mem[rd_addr];
    end

    assign busy   = (state_reg != S_IDLE);
    assign strobe = strobe_reg;
    assign result = result_reg;

endmodule

FILE: src/itf_checker.sv
// Port-level checks for the integer-to-text formatter, bound to the top level.
`timescale 1ns / 1ps

module itf_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input logic              strobe,
    input itf_pkg::itf_out_t result
);

    // an accepted transaction makes the block busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accepted transaction");

    // characters only follow a busy cycle
    a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> $past(busy))
        else $error("strobe without prior busy");

    // characters of one number come back to back
    a_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && !result.last) |=> strobe)
        else $error("gap inside a number's text");

    // busy drops exactly as the final character shows
    a_fell_last: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> (strobe && result.last))
        else $error("busy fell without final character");

    a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && result.last) |=> !strobe)
        else $error("strobe right after final character");

endmodule

bind integer_to_text_formatter itf_checker u_itf_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .strobe (strobe),
    .result (result)
);
